/* rtl/uartrx_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared types, register slots and reset values for the UART register block.
// ----------------------------------------------------------------------------
package uartrx_pkg;

    localparam int RX_DEPTH_DEFAULT = 64;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RECV  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_UNKNOWN  = 2'd1,
        ERR_READONLY = 2'd2,
        ERR_RSVD     = 2'd3
    } access_err_t;

    // register file slots
    localparam logic [3:0] R_CR      = 4'd0;
    localparam logic [3:0] R_MR      = 4'd1;
    localparam logic [3:0] R_IER     = 4'd2;
    localparam logic [3:0] R_IDR     = 4'd3;
    localparam logic [3:0] R_IMR     = 4'd4;
    localparam logic [3:0] R_ISR     = 4'd5;
    localparam logic [3:0] R_BAUD    = 4'd6;
    localparam logic [3:0] R_RXTOUT  = 4'd7;
    localparam logic [3:0] R_RXWM    = 4'd8;
    localparam logic [3:0] R_MODEMCR = 4'd9;
    localparam logic [3:0] R_MODEMSR = 4'd10;
    localparam logic [3:0] R_SR      = 4'd11;
    localparam logic [3:0] R_FIFO    = 4'd12;
    localparam logic [3:0] R_BDIV    = 4'd13;
    localparam logic [3:0] R_FLOW    = 4'd14;
    localparam logic [3:0] R_TXWM    = 4'd15;

    localparam logic [4:0] ADDR_LAST_DIRECT = 5'd14;
    localparam logic [4:0] ADDR_TXWM        = 5'd17;

    localparam logic [31:0] RST_CR   = 32'h0000_0128;
    localparam logic [31:0] RST_BAUD = 32'h0000_028B;
    localparam logic [31:0] RST_RXWM = 32'h0000_0020;
    localparam logic [31:0] RST_BDIV = 32'h0000_000F;
    localparam logic [31:0] RST_TXWM = 32'h0000_0020;

    localparam logic [31:0] CR_WRITE_MASK = 32'h0000_01FC;

    localparam logic [1:0] MODE_LOOPBACK = 2'd2;

    localparam logic [7:0] CHAR_DEL = 8'd127;
    localparam logic [7:0] CHAR_BS  = 8'd8;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    typedef struct packed {
        action_t     action;
        logic [4:0]  word_address;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_raise;
        logic        irq_lower;
        access_err_t access_error;
        logic        fifo_pop;
    } result_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } fifo_ctrl_t;

endpackage
`default_nettype wire

/* rtl/uartrx_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_fifo
// Receive byte store with head/tail pointers, fill count and registered pop data.
// ----------------------------------------------------------------------------
module uartrx_fifo #(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  uartrx_pkg::fifo_ctrl_t   ctrl,
    output logic [CW-1:0]            count,
    output logic [7:0]               rd_data
);
    import uartrx_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    rd_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next  = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            head_next  = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= ctrl.wdata;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign count   = count_reg;
    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/uartrx_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_regs
// Register file, address decode, receive mapping and interrupt/status update.
// ----------------------------------------------------------------------------
module uartrx_regs #(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      advance,
    input  uartrx_pkg::item_t        item,
    input  wire [CW-1:0]             fifo_count,
    output uartrx_pkg::fifo_ctrl_t   fifo_ctrl,
    output uartrx_pkg::result_t      result
);
    import uartrx_pkg::*;

    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [31:0] regs_reg  [16];
    logic [31:0] regs_next [16];

    logic          slot_ok;
    logic [3:0]    slot;
    logic          do_recv;
    logic [7:0]    raw_byte;
    logic [7:0]    mapped;
    logic          push;
    logic          pop;
    logic [CW-1:0] cnt_after;
    logic [CMPW-1:0] cnt_cmp;
    logic [CMPW-1:0] wm_cmp;

    // power-up value of one register slot
    function automatic logic [31:0] reset_value(input logic [3:0] idx);
        logic [31:0] v;
        unique case (idx)
            R_CR:    v = RST_CR;
            R_BAUD:  v = RST_BAUD;
            R_RXWM:  v = RST_RXWM;
            R_BDIV:  v = RST_BDIV;
            R_TXWM:  v = RST_TXWM;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        slot_ok = 1'b1;
        slot    = item.word_address[3:0];
        if (item.word_address == ADDR_TXWM)
        begin
            slot = R_TXWM;
        end
        else if (item.word_address > ADDR_LAST_DIRECT)
        begin
            slot_ok = 1'b0;
        end
    end

    always_comb
    begin
        raw_byte = (item.action == ACT_RECV) ? item.rx_byte : item.write_data[7:0];
        mapped   = raw_byte;
        if (raw_byte == CHAR_DEL)
        begin
            mapped = CHAR_BS;
        end
        else if (raw_byte == CHAR_LF || raw_byte == CHAR_CR)
        begin
            mapped = CHAR_CR;
        end
    end

    assign do_recv = (item.action == ACT_RECV)
                  || (item.action == ACT_WRITE && slot_ok && slot == R_FIFO
                      && regs_reg[R_MR][9:8] == MODE_LOOPBACK);

    assign push = do_recv && !regs_reg[R_MR][8] && (fifo_count != FULL);
    assign pop  = (item.action == ACT_READ) && slot_ok && (slot == R_FIFO)
                && (fifo_count != '0);

    assign cnt_after = push ? fifo_count + 1'b1 : (pop ? fifo_count - 1'b1 : fifo_count);
    assign cnt_cmp   = CMPW'(cnt_after);
    assign wm_cmp    = CMPW'(regs_reg[R_RXWM][5:0]);

    always_comb
    begin
        regs_next = regs_reg;
        result    = '0;

        // receive side effects come first, a loopback FIFO write then overrides tx
        if (do_recv)
        begin
            if (regs_reg[R_MR][8])
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = mapped;
            end
            else if (cnt_cmp == wm_cmp)
            begin
                regs_next[R_SR][0]  = 1'b1;
                regs_next[R_ISR][0] = 1'b1;
            end
            regs_next[R_SR][1]  = 1'b0;
            regs_next[R_SR][2]  = 1'b1;
            regs_next[R_ISR][0] = 1'b1;
            result.irq_raise    = 1'b1;
        end

        unique case (item.action)
            ACT_READ:
            begin
                if (!slot_ok)
                begin
                    result.access_error = ERR_UNKNOWN;
                end
                else if (slot == R_FIFO)
                begin
                    result.fifo_pop = pop;
                    if (cnt_cmp < wm_cmp)
                    begin
                        regs_next[R_SR][0] = 1'b0;
                    end
                    if (cnt_after == '0)
                    begin
                        regs_next[R_SR][1] = 1'b1;
                        regs_next[R_SR][2] = 1'b0;
                        if (regs_reg[R_IER][1] && regs_reg[R_IMR][1])
                        begin
                            regs_next[R_ISR][1] = 1'b1;
                            result.irq_raise    = 1'b1;
                        end
                    end
                end
                else
                begin
                    result.read_data = regs_reg[slot];
                end
            end
            ACT_WRITE:
            begin
                if (!slot_ok)
                begin
                    result.access_error = ERR_UNKNOWN;
                end
                else
                begin
                    unique case (slot)
                        R_IMR, R_SR:
                        begin
                            result.access_error = ERR_READONLY;
                        end
                        R_CR:
                        begin
                            regs_next[R_CR] = item.write_data & CR_WRITE_MASK;
                        end
                        R_IER:
                        begin
                            regs_next[R_IER] = item.write_data;
                            regs_next[R_IMR] = regs_reg[R_IMR] | item.write_data;
                        end
                        R_IDR:
                        begin
                            regs_next[R_IDR] = item.write_data;
                            regs_next[R_IMR] = regs_reg[R_IMR] & ~item.write_data;
                        end
                        R_ISR:
                        begin
                            regs_next[R_ISR] = regs_reg[R_ISR] & ~item.write_data;
                            result.irq_lower = 1'b1;
                        end
                        R_FIFO:
                        begin
                            regs_next[R_FIFO]   = item.write_data;
                            result.tx_valid     = 1'b1;
                            result.tx_byte      = item.write_data[7:0];
                            regs_next[R_SR][11] = 1'b0;
                            regs_next[R_SR][4]  = 1'b0;
                            regs_next[R_SR][3]  = 1'b1;
                            if (regs_reg[R_IER][3] && regs_reg[R_IMR][3])
                            begin
                                regs_next[R_ISR][3] = 1'b1;
                                result.irq_raise    = 1'b1;
                            end
                        end
                        default:
                        begin
                            regs_next[slot] = item.write_data;
                        end
                    endcase
                end
            end
            ACT_RECV:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        fifo_ctrl.push  = advance && push;
        fifo_ctrl.pop   = advance && pop;
        fifo_ctrl.wdata = mapped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                regs_reg[i] <= reset_value(4'(i));
            end
        end
        else if (advance)
        begin
            regs_reg <= regs_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/uart_registers_with_rx_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uart_registers_with_rx_fifo
// UART register block with receive FIFO, status bits and interrupt flags.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes the input register, then the result register
//   behind the decode/update logic, and leaves as its result beat.
// Throughput: one beat per cycle while m_tready is high; the result register lets a
//   new beat enter while a finished one waits for m_tready.
// Reset: rst_n clears the register file to its defaults, the FIFO pointers and
//   count, and both valid flags. FIFO storage holds no reset and needs no sweep.
// ----------------------------------------------------------------------------
module uart_registers_with_rx_fifo #(
    parameter int RX_DEPTH = uartrx_pkg::RX_DEPTH_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    // input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [47:0]  s_tdata,   // word_address[4:0], write_data[36:5], rx_byte[44:37]
    input  wire [1:0]   s_tuser,   // action[1:0]
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // read_data[31:0], tx_valid[32], tx_byte[40:33],
                                   // irq_raise[41], irq_lower[42], access_error[44:43]
);
    import uartrx_pkg::*;

    localparam int CW = $clog2(RX_DEPTH + 1);

    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg;

    logic       s_accept;
    logic       advance;
    result_t    result;
    fifo_ctrl_t fifo_ctrl;
    logic [CW-1:0] fifo_count;
    logic [7:0] fifo_rd;
    logic [31:0] read_data;

    // Advance the held beat when the result slot is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat and, on advance, the result; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.action       <= action_t'(s_tuser);
            in_item_reg.word_address <= s_tdata[4:0];
            in_item_reg.write_data   <= s_tdata[36:5];
            in_item_reg.rx_byte      <= s_tdata[44:37];
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    uartrx_regs #(
        .DEPTH (RX_DEPTH)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (in_item_reg),
        .fifo_count (fifo_count),
        .fifo_ctrl  (fifo_ctrl),
        .result     (result)
    );

    uartrx_fifo #(
        .DEPTH (RX_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (fifo_ctrl),
        .count   (fifo_count),
        .rd_data (fifo_rd)
    );

    // Popped byte arrives in the FIFO's read register on the same edge as the result.
    assign read_data = res_reg.fifo_pop ? {24'd0, fifo_rd} : res_reg.read_data;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0,
                       res_reg.access_error,
                       res_reg.irq_lower,
                       res_reg.irq_raise,
                       res_reg.tx_byte,
                       res_reg.tx_valid,
                       read_data};

endmodule
`default_nettype wire
